// ===== rtl/lapool_pkg.sv =====
// ----------------------------------------------------------------------------
// Lease address pool package
// Shared beat types, message and reply codes, entry status codes and the
// controller state type of the lease address pool server.
// ----------------------------------------------------------------------------
`default_nettype none

package lapool_pkg;

    localparam int TIME_IN_W    = 30;
    localparam int TIME_W       = 31;
    localparam int HOST_FIELD_W = 16;
    localparam int ADDR_W       = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 30;
    localparam int POOL_SIZE_W  = 9;

    localparam logic [1:0] CMD_DISCOVER = 2'd0;
    localparam logic [1:0] CMD_REQUEST  = 2'd1;

    localparam logic [1:0] REPLY_OFFER = 2'd0;
    localparam logic [1:0] REPLY_ACK   = 2'd1;
    localparam logic [1:0] REPLY_NAK   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_POOL_SIZE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_LEASE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEASE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LEASE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SERVER_ID     = 3'd4;

    localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RESET = 9'd256;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_OFFER   = 2'd1,
        ST_LEASE   = 2'd2,
        ST_EXPIRED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    typedef struct packed {
        logic [TIME_IN_W-1:0]    arrival_time;
        logic [HOST_FIELD_W-1:0] sender_id;
        logic [HOST_FIELD_W-1:0] receiver_id;
        logic                    receiver_is_any;
        logic [1:0]              cmd;
        logic [ADDR_W-1:0]       requested_addr;
        logic [TIME_W-1:0]       requested_expire;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]              reply_kind;
        logic [HOST_FIELD_W-1:0] client_id;
        logic [ADDR_W-1:0]       reply_addr;
        logic [TIME_W-1:0]       reply_expire;
    } out_beat_t;

    typedef struct packed {
        logic [TIME_IN_W-1:0] default_lease;
        logic [TIME_IN_W-1:0] max_lease;
        logic [TIME_IN_W-1:0] min_lease;
    } lease_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lapool_ram.sv =====
// ----------------------------------------------------------------------------
// Lease address pool RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lapool_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/lapool_grant.sv =====
// ----------------------------------------------------------------------------
// Lease address pool expiry grant
// Registers the lease bounds of a message and clamps its wanted expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module lapool_grant
    import lapool_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire logic [TIME_IN_W-1:0] arrival_time,
    input  wire logic [TIME_W-1:0]    requested_expire,
    input  wire lease_cfg_t           lease_cfg,
    output logic      [TIME_W-1:0]    grant_expire
);

    logic [TIME_W-1:0] lo_reg, lo_next;
    logic [TIME_W-1:0] hi_reg, hi_next;
    logic [TIME_W-1:0] dflt_reg, dflt_next;
    logic [TIME_W-1:0] want_reg;
    logic [TIME_W-1:0] grant_reg, grant_next;

    // Both operands stay below 2^30, so the sums never reach the top of the range.
    assign lo_next   = {1'b0, arrival_time} + {1'b0, lease_cfg.min_lease};
    assign hi_next   = {1'b0, arrival_time} + {1'b0, lease_cfg.max_lease};
    assign dflt_next = {1'b0, arrival_time} + {1'b0, lease_cfg.default_lease};

    always_comb
    begin
        grant_next = want_reg;
        if (want_reg == '0)
        begin
            grant_next = dflt_reg;
        end
        else
        begin
            if (want_reg < lo_reg)
            begin
                grant_next = lo_reg;
            end
            if (want_reg > hi_reg)
            begin
                grant_next = hi_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            dflt_reg <= dflt_next;
            want_reg <= requested_expire;
        end
        grant_reg <= grant_next;
    end

    assign grant_expire = grant_reg;

endmodule

`default_nettype wire

// ===== rtl/lapool_engine.sv =====
// ----------------------------------------------------------------------------
// Lease address pool engine
// Sweeps the pool memory once per message: ages each entry, releases offers,
// tracks the candidate entries, then commits the offer or lease and replies.
// ----------------------------------------------------------------------------
`default_nettype none

module lapool_engine
    import lapool_pkg::*;
#(
    parameter int POOL_DEPTH   = 256,
    parameter int HOST_ID_BITS = 16,
    localparam int AW   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
    localparam int CW   = $clog2(POOL_DEPTH + 1),
    localparam int ID_W = (HOST_ID_BITS < HOST_FIELD_W) ? HOST_ID_BITS : HOST_FIELD_W,
    localparam int EW   = 2 + ID_W + TIME_W
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire in_beat_t                item_in,
    input  wire logic [CW-1:0]           pool_n,
    input  wire logic [HOST_FIELD_W-1:0] server_id,
    input  wire logic [TIME_W-1:0]       grant_expire,
    input  wire logic                    out_free,
    output logic                         idle,
    output logic                         ram_we,
    output logic      [AW-1:0]           ram_waddr,
    output logic      [EW-1:0]           ram_wdata,
    output logic      [AW-1:0]           ram_raddr,
    input  wire logic [EW-1:0]           ram_rdata,
    output logic                         res_valid,
    output out_beat_t                    res_beat
);

    state_t            state_reg, state_next;
    in_beat_t          item_reg, item_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic              own_found_reg, own_found_next;
    logic [AW-1:0]     own_idx_reg, own_idx_next;
    logic              free_found_reg, free_found_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;
    logic              exp_found_reg, exp_found_next;
    logic [AW-1:0]     exp_idx_reg, exp_idx_next;
    logic              req_owned_reg, req_owned_next;

    logic [ID_W-1:0]   who;
    logic [TIME_W-1:0] t_now;
    logic              is_disc, is_req, to_us, release_mode, req_here, addr_ok;
    logic [AW-1:0]     req_idx;
    logic              issue_more;

    status_t           rd_status;
    logic [ID_W-1:0]   rd_owner;
    logic [TIME_W-1:0] rd_expire;
    status_t           aged_status, wb_status;
    logic [ID_W-1:0]   aged_owner, wb_owner;
    logic [TIME_W-1:0] aged_expire, wb_expire;
    logic              owned;

    logic              pick_found;
    logic [AW-1:0]     pick_idx;
    logic              offer_go, ack_go, nak_go;

    assign who     = item_reg.sender_id[ID_W-1:0];
    assign t_now   = {1'b0, item_reg.arrival_time};
    assign is_disc = (item_reg.cmd == CMD_DISCOVER) && item_reg.receiver_is_any;
    assign is_req  = (item_reg.cmd == CMD_REQUEST) && !item_reg.receiver_is_any;
    assign to_us   = item_reg.receiver_id[ID_W-1:0] == server_id[ID_W-1:0];
    assign release_mode = is_req && !to_us;
    assign req_here     = is_req && to_us;
    assign addr_ok = (item_reg.requested_addr != '0)
                     && (32'(item_reg.requested_addr) <= 32'(pool_n));
    assign req_idx = AW'(item_reg.requested_addr - ADDR_W'(1));
    assign issue_more = idx_reg < pool_n;

    assign rd_status = status_t'(ram_rdata[EW-1 -: 2]);
    assign rd_owner  = ram_rdata[TIME_W +: ID_W];
    assign rd_expire = ram_rdata[TIME_W-1:0];

    always_comb
    begin
        aged_status = rd_status;
        aged_owner  = rd_owner;
        aged_expire = rd_expire;
        if (t_now >= rd_expire)
        begin
            if (rd_status == ST_OFFER)
            begin
                aged_status = ST_FREE;
                aged_owner  = '0;
                aged_expire = '0;
            end
            else if (rd_status == ST_LEASE)
            begin
                aged_status = ST_EXPIRED;
                aged_expire = '0;
            end
        end
        owned     = (aged_status != ST_FREE) && (aged_owner == who);
        wb_status = aged_status;
        wb_owner  = aged_owner;
        wb_expire = aged_expire;
        if (release_mode && (aged_status == ST_OFFER) && (aged_owner == who))
        begin
            wb_status = ST_FREE;
            wb_owner  = '0;
            wb_expire = '0;
        end
    end

    always_comb
    begin
        pick_found = own_found_reg || free_found_reg || exp_found_reg;
        priority if (own_found_reg)
        begin
            pick_idx = own_idx_reg;
        end
        else if (free_found_reg)
        begin
            pick_idx = free_idx_reg;
        end
        else
        begin
            pick_idx = exp_idx_reg;
        end
        offer_go = is_disc && pick_found;
        ack_go   = req_here && addr_ok && req_owned_reg;
        nak_go   = req_here && addr_ok && !req_owned_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == CW'(POOL_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!rd_valid_reg && !issue_more)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: memory writes and the reply beat.
    always_comb
    begin
        idle      = state_reg == S_IDLE;
        ram_raddr = idx_reg[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = rd_idx_reg;
        ram_wdata = {wb_status, wb_owner, wb_expire};
        res_valid = 1'b0;
        res_beat.reply_kind   = REPLY_OFFER;
        res_beat.client_id    = HOST_FIELD_W'(who);
        res_beat.reply_addr   = item_reg.requested_addr;
        res_beat.reply_expire = grant_expire;
        if (offer_go)
        begin
            res_beat.reply_addr = ADDR_W'(pick_idx) + ADDR_W'(1);
        end
        else if (ack_go)
        begin
            res_beat.reply_kind = REPLY_ACK;
        end
        else
        begin
            res_beat.reply_kind   = REPLY_NAK;
            res_beat.reply_expire = '0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                ram_we = 1'b0;
            end
            S_SCAN:
            begin
                ram_we = rd_valid_reg;
            end
            S_DECIDE:
            begin
                ram_we    = out_free && (offer_go || ack_go);
                ram_waddr = offer_go ? pick_idx : req_idx;
                ram_wdata = {(offer_go ? ST_OFFER : ST_LEASE), who, grant_expire};
                res_valid = out_free && (offer_go || ack_go || nak_go);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sweep counter and search trackers.
    always_comb
    begin
        item_next       = item_reg;
        idx_next        = idx_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        own_found_next  = own_found_reg;
        own_idx_next    = own_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        exp_found_next  = exp_found_reg;
        exp_idx_next    = exp_idx_reg;
        req_owned_next  = req_owned_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + CW'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next       = item_in;
                    idx_next        = '0;
                    own_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    exp_found_next  = 1'b0;
                    req_owned_next  = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (issue_more)
                begin
                    idx_next      = idx_reg + CW'(1);
                    rd_valid_next = 1'b1;
                    rd_idx_next   = idx_reg[AW-1:0];
                end
                if (rd_valid_reg)
                begin
                    if (owned && !own_found_reg)
                    begin
                        own_found_next = 1'b1;
                        own_idx_next   = rd_idx_reg;
                    end
                    if ((aged_status == ST_FREE) && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                    if ((aged_status == ST_EXPIRED) && !exp_found_reg)
                    begin
                        exp_found_next = 1'b1;
                        exp_idx_next   = rd_idx_reg;
                    end
                    if (rd_idx_reg == req_idx)
                    begin
                        req_owned_next = owned;
                    end
                end
            end
            S_DECIDE:
            begin
                idx_next = idx_reg;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            own_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            exp_found_reg  <= 1'b0;
            req_owned_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_valid_next;
            own_found_reg  <= own_found_next;
            free_found_reg <= free_found_next;
            exp_found_reg  <= exp_found_next;
            req_owned_reg  <= req_owned_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        rd_idx_reg   <= rd_idx_next;
        own_idx_reg  <= own_idx_next;
        free_idx_reg <= free_idx_next;
        exp_idx_reg  <= exp_idx_next;
    end

endmodule

`default_nettype wire

// ===== rtl/lease_address_pool_server_top.sv =====
// ----------------------------------------------------------------------------
// Lease address pool server
// Keeps a pool of leased addresses and answers discover and request messages.
// ----------------------------------------------------------------------------
// Messages enter as beats on in_valid/in_stall/in_data; replies leave as
// beats on out_valid/out_stall/out_data. A message yields zero or one reply.
// Registers are to be written through cfg_we/cfg_index/cfg_data only while
// no message is in flight; the block itself does not enforce this.
// Each accepted message sweeps the pool memory through its single read port,
// one entry per cycle, aging entries and collecting candidates; the commit
// state then writes the offer or lease. N = min(pool_size, POOL_DEPTH)
// entries are swept, none when the pool is empty, and in_stall stays high
// from acceptance until the engine leaves its commit state.
// The reply sits in an output register; the next message is accepted while
// it waits. If the receiver stalls while that register is full, the engine
// holds in its commit state until the output register frees up.
// After reset the block clears every entry of the pool memory, one per
// cycle, with in_stall high.
// ----------------------------------------------------------------------------
`default_nettype none

module lease_address_pool_server_top
    import lapool_pkg::*;
#(
    parameter int POOL_DEPTH   = 256,
    parameter int HOST_ID_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_beat_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_beat_t                   out_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW   = $clog2(POOL_DEPTH + 1);
    localparam int ID_W = (HOST_ID_BITS < HOST_FIELD_W) ? HOST_ID_BITS : HOST_FIELD_W;
    localparam int EW   = 2 + ID_W + TIME_W;

    logic [POOL_SIZE_W-1:0]  pool_size_reg;
    lease_cfg_t              lease_cfg_reg;
    logic [HOST_FIELD_W-1:0] server_id_reg;

    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_data_reg;

    logic              eng_idle, start, out_free;
    logic [CW-1:0]     pool_n;
    logic [TIME_W-1:0] grant_expire;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [EW-1:0]     ram_wdata, ram_rdata;
    logic              res_valid;
    out_beat_t         res_beat;

    assign in_stall = !eng_idle;
    assign start    = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign pool_n   = (32'(pool_size_reg) > 32'(POOL_DEPTH)) ? CW'(POOL_DEPTH)
                                                             : CW'(pool_size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_SIZE_RESET;
            lease_cfg_reg <= '0;
            server_id_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POOL_SIZE:     pool_size_reg               <= cfg_data[POOL_SIZE_W-1:0];
                REG_DEFAULT_LEASE: lease_cfg_reg.default_lease <= cfg_data;
                REG_MAX_LEASE:     lease_cfg_reg.max_lease     <= cfg_data;
                REG_MIN_LEASE:     lease_cfg_reg.min_lease     <= cfg_data;
                REG_SERVER_ID:     server_id_reg               <= cfg_data[HOST_FIELD_W-1:0];
                default:           server_id_reg               <= server_id_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res_beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    lapool_ram #(
        .WIDTH (EW),
        .DEPTH (POOL_DEPTH)
    ) u_pool_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lapool_grant u_grant (
        .clk              (clk),
        .load             (start),
        .arrival_time     (in_data.arrival_time),
        .requested_expire (in_data.requested_expire),
        .lease_cfg        (lease_cfg_reg),
        .grant_expire     (grant_expire)
    );

    lapool_engine #(
        .POOL_DEPTH   (POOL_DEPTH),
        .HOST_ID_BITS (HOST_ID_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item_in      (in_data),
        .pool_n       (pool_n),
        .server_id    (server_id_reg),
        .grant_expire (grant_expire),
        .out_free     (out_free),
        .idle         (eng_idle),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .res_valid    (res_valid),
        .res_beat     (res_beat)
    );

endmodule

`default_nettype wire
